@@ sv/servo_gesture_sequencer_assert.svh @@
// assertion macros shared by the servo gesture sequencer rtl
// needs a clock and an active-low reset name at the point of use
`ifndef SERVO_GESTURE_SEQUENCER_ASSERT_SVH
`define SERVO_GESTURE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sgs_pkg.sv @@
// types, codes and reset values for the servo gesture sequencer
// no dependencies
package sgs_pkg;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_SET    = 3'd1;
  localparam logic [2:0] FUNC_ROTATE = 3'd2;
  localparam logic [2:0] FUNC_WIGGLE = 3'd3;
  localparam logic [2:0] FUNC_STOP   = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ROTATE = 2'd1,
    MODE_WIGGLE = 2'd2
  } sgs_mode_t;

  typedef enum logic [2:0] {
    REG_ROT_INT = 3'd0,
    REG_ROT_DUR = 3'd1,
    REG_WIG_INT = 3'd2,
    REG_MIN_ANG = 3'd3,
    REG_MAX_ANG = 3'd4,
    REG_CTR_ANG = 3'd5
  } sgs_reg_t;

  localparam logic [15:0] ROT_INT_RST = 16'd250;
  localparam logic [15:0] ROT_DUR_RST = 16'd3000;
  localparam logic [15:0] WIG_INT_RST = 16'd150;
  localparam logic [7:0]  MIN_ANG_RST = 8'd0;
  localparam logic [7:0]  MAX_ANG_RST = 8'd180;
  localparam logic [7:0]  CTR_ANG_RST = 8'd90;

  localparam logic signed [16:0] WIGGLE_LO = 17'sd60;
  localparam logic signed [16:0] WIGGLE_HI = 17'sd120;

  typedef struct packed {
    logic [15:0] rot_int;
    logic [15:0] rot_dur;
    logic [15:0] wig_int;
    logic [7:0]  min_ang;
    logic [7:0]  max_ang;
    logic [7:0]  ctr_ang;
  } sgs_cfg_t;

  typedef struct packed {
    logic       angle_valid;
    logic [7:0] servo_angle;
    logic [1:0] mode;
    logic       last;
  } sgs_result_t;

  // below min gives min, otherwise above max gives max
  function automatic logic [7:0] clamp_deg(logic signed [16:0] a,
                                           logic [7:0] lo, logic [7:0] hi);
    logic signed [16:0] lo_s;
    logic signed [16:0] hi_s;
    lo_s = $signed({9'd0, lo});
    hi_s = $signed({9'd0, hi});
    if (a < lo_s) begin
      clamp_deg = lo;
    end else if (a > hi_s) begin
      clamp_deg = hi;
    end else begin
      clamp_deg = a[7:0];
    end
  endfunction

endpackage

@@ sv/sgs_if.sv @@
// handshake channels of the servo gesture sequencer: commands, results, register writes
// no dependencies
interface sgs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [15:0] angle;
  modport source (output valid, func, angle, input ready);
  modport sink (input valid, func, angle, output ready);
endinterface

interface sgs_out_if;
  logic       valid;
  logic       ready;
  logic       angle_valid;
  logic [7:0] servo_angle;
  logic [1:0] mode;
  logic       last;
  modport source (output valid, angle_valid, servo_angle, mode, last, input ready);
  modport sink (input valid, angle_valid, servo_angle, mode, last, output ready);
endinterface

interface sgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/servo_gesture_sequencer.sv @@
// top level of the servo gesture sequencer: register file, step logic and result buffer
// depends on sgs_pkg, sgs_if and sgs_step

// Commands and one-millisecond ticks go in, servo target words come out in the cycle
// after acceptance. Each command gives one result word, or two when a rotate step
// also reaches the duration and parks at centre; the last word carries last. A
// command is taken as the last word of the one before drains: one command per cycle
// for one-word commands while out_ch is ready; a two-word one holds the next off
// until the result buffer hands out both its words, one a cycle while out_ch is ready.
// Register writes are ready out of reset and take effect at the next clock edge.
module servo_gesture_sequencer (
  input logic      clk,
  input logic      rst_n,
  sgs_in_if.sink   in_ch,
  sgs_out_if.source out_ch,
  sgs_cfg_if.sink  cfg_ch
);
  import sgs_pkg::*;
  `include "servo_gesture_sequencer_assert.svh"

  sgs_cfg_t    cfg_r;
  sgs_result_t res0, res1;
  logic        two;
  sgs_result_t res0_r, res1_r;
  logic        two_r;
  logic        buf_valid_r;
  logic        sel_r;
  logic        accept;
  logic        out_fire;
  logic        drain_last;
  sgs_result_t cur;

  // register file
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{rot_int: ROT_INT_RST, rot_dur: ROT_DUR_RST, wig_int: WIG_INT_RST,
                 min_ang: MIN_ANG_RST, max_ang: MAX_ANG_RST, ctr_ang: CTR_ANG_RST};
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROT_INT: cfg_r.rot_int <= cfg_ch.data;
        REG_ROT_DUR: cfg_r.rot_dur <= cfg_ch.data;
        REG_WIG_INT: cfg_r.wig_int <= cfg_ch.data;
        REG_MIN_ANG: cfg_r.min_ang <= cfg_ch.data[7:0];
        REG_MAX_ANG: cfg_r.max_ang <= cfg_ch.data[7:0];
        REG_CTR_ANG: cfg_r.ctr_ang <= cfg_ch.data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign out_fire     = buf_valid_r && out_ch.ready;
  assign drain_last   = out_fire && (sel_r || !two_r);
  assign in_ch.ready  = rst_n && (!buf_valid_r || drain_last);
  assign accept       = in_ch.valid && in_ch.ready;

  sgs_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .func   (in_ch.func),
    .angle  (in_ch.angle),
    .cfg    (cfg_r),
    .res0   (res0),
    .res1   (res1),
    .two    (two)
  );

  // result buffer: holds both words of one command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (accept) begin
      buf_valid_r <= 1'b1;
      sel_r       <= 1'b0;
    end else if (drain_last) begin
      buf_valid_r <= 1'b0;
    end else if (out_fire) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res0_r <= res0;
      res1_r <= res1;
      two_r  <= two;
    end
  end

  assign cur                = sel_r ? res1_r : res0_r;
  assign out_ch.valid       = buf_valid_r;
  assign out_ch.angle_valid = cur.angle_valid;
  assign out_ch.servo_angle = cur.servo_angle;
  assign out_ch.mode        = cur.mode;
  assign out_ch.last        = cur.last;

  `SGS_ASSERT_NXT(a_accept_gives_word, clk, rst_n, accept, out_ch.valid && !sel_r, "accepted command produced no result word")
  `SGS_ASSERT_NXT(a_second_word_follows, clk, rst_n, out_fire && !out_ch.last, out_ch.valid && sel_r, "second result word missing after first")
  `SGS_ASSERT_IMP(a_empty_word_is_last, clk, rst_n, out_ch.valid && !out_ch.angle_valid, out_ch.last && out_ch.servo_angle == 8'd0, "word without angle is not a lone zero word")

endmodule

@@ sv/sgs_step.sv @@
// motion state and per-command step logic of the servo gesture sequencer
// depends on sgs_pkg
module sgs_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          func,
  input  logic signed [15:0]  angle,
  input  sgs_pkg::sgs_cfg_t   cfg,
  output sgs_pkg::sgs_result_t res0,
  output sgs_pkg::sgs_result_t res1,
  output logic                two
);
  import sgs_pkg::*;

  sgs_mode_t   mode_r, mode_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic [15:0] wait_dec;
  logic [15:0] elapsed_inc;
  logic [7:0]  rot_ang;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      step_r    <= 2'd0;
      wait_r    <= 16'd0;
      elapsed_r <= 16'd0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      step_r    <= step_nxt;
      wait_r    <= wait_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign wait_dec    = (wait_r == 16'd0) ? 16'd0 : wait_r - 16'd1;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign rot_ang     = step_r[0] ? cfg.min_ang : cfg.max_ang;

  always_comb begin
    mode_nxt    = mode_r;
    step_nxt    = step_r;
    wait_nxt    = wait_r;
    elapsed_nxt = elapsed_r;
    two         = 1'b0;
    res0        = '{angle_valid: 1'b0, servo_angle: 8'd0, mode: mode_r, last: 1'b1};
    res1        = '{angle_valid: 1'b1, servo_angle: cfg.ctr_ang, mode: MODE_IDLE,
                    last: 1'b1};
    unique case (func) inside
      FUNC_TICK: begin
        wait_nxt    = wait_dec;
        elapsed_nxt = elapsed_inc;
        if (wait_dec == 16'd0 && mode_r == MODE_ROTATE) begin
          step_nxt = step_r + 2'd1;
          wait_nxt = cfg.rot_int;
          res0     = '{angle_valid: 1'b1, servo_angle: rot_ang, mode: MODE_ROTATE,
                       last: 1'b1};
          // duration reached: second word parks at centre
          if (elapsed_inc >= cfg.rot_dur) begin
            mode_nxt  = MODE_IDLE;
            res0.last = 1'b0;
            two       = 1'b1;
          end
        end else if (wait_dec == 16'd0 && mode_r == MODE_WIGGLE) begin
          step_nxt = step_r + 2'd1;
          case (step_r)
            2'd0: begin
              wait_nxt = cfg.wig_int;
              res0 = '{angle_valid: 1'b1,
                       servo_angle: clamp_deg(WIGGLE_LO, cfg.min_ang, cfg.max_ang),
                       mode: MODE_WIGGLE, last: 1'b1};
            end
            2'd1: begin
              wait_nxt = cfg.wig_int;
              res0 = '{angle_valid: 1'b1,
                       servo_angle: clamp_deg(WIGGLE_HI, cfg.min_ang, cfg.max_ang),
                       mode: MODE_WIGGLE, last: 1'b1};
            end
            default: begin
              mode_nxt = MODE_IDLE;
              res0 = '{angle_valid: 1'b1, servo_angle: cfg.ctr_ang, mode: MODE_IDLE,
                       last: 1'b1};
            end
          endcase
        end
      end
      FUNC_SET: begin
        res0 = '{angle_valid: 1'b1,
                 servo_angle: clamp_deg({angle[15], angle}, cfg.min_ang, cfg.max_ang),
                 mode: mode_r, last: 1'b1};
      end
      FUNC_ROTATE, FUNC_WIGGLE: begin
        mode_nxt    = (func == FUNC_ROTATE) ? MODE_ROTATE : MODE_WIGGLE;
        step_nxt    = 2'd0;
        wait_nxt    = 16'd0;
        elapsed_nxt = 16'd0;
        res0.mode   = mode_nxt;
      end
      FUNC_STOP: begin
        mode_nxt = MODE_IDLE;
        res0 = '{angle_valid: 1'b1, servo_angle: cfg.ctr_ang, mode: MODE_IDLE,
                 last: 1'b1};
      end
      default: begin
      end
    endcase
  end

endmodule
